/* src/ents_pkg.sv */
// Shared types and constants for the entab tab stop block.
// Used by ents_dist and entab_tab_stops; depends on nothing.
package ents_pkg;

    // Fixed field widths
    localparam int STOP_BITS     = 12;
    localparam int IV_BITS       = 6;
    localparam int RUN_BITS      = 6;
    localparam int BYTE_BITS     = 8;
    localparam int CFG_IDX_BITS  = 3;
    localparam int CFG_DATA_BITS = 12;
    localparam int COUNT_BITS    = 3;

    // Run length cap and the interval used when the register holds zero
    localparam logic [RUN_BITS-1:0] RUN_CAP           = 6'd63;
    localparam logic [IV_BITS-1:0]  FALLBACK_INTERVAL = 6'd8;

    // Character codes
    localparam logic [BYTE_BITS-1:0] CH_TAB   = 8'd9;
    localparam logic [BYTE_BITS-1:0] CH_NL    = 8'd10;
    localparam logic [BYTE_BITS-1:0] CH_BLANK = 8'd32;

    // Register indexes on the configuration port
    localparam logic [CFG_IDX_BITS-1:0] REG_STOP_COUNT = 3'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_STOP_A     = 3'd1;
    localparam logic [CFG_IDX_BITS-1:0] REG_INTERVAL   = 3'd7;

    // Reset values of the configuration registers
    localparam logic [STOP_BITS-1:0] STOP_RESET     = 12'd1;
    localparam logic [IV_BITS-1:0]   INTERVAL_RESET = 6'd8;

    // Top level sequencer
    typedef enum logic [2:0] {
        S_IDLE,
        S_DIST,
        S_PLAN,
        S_SPACE,
        S_LAST
    } ents_state_t;

    // Distance unit sequencer
    typedef enum logic [2:0] {
        D_IDLE,
        D_SEARCH,
        D_BASE,
        D_MOD,
        D_FINAL
    } dist_state_t;

endpackage

/* src/ents_dist.sv */
// Distance from a column to the next tab stop, found with one shared subtractor.
// Scans the user stops one per cycle; when the column lies past the last one, it
// reduces modulo the default interval one bit per cycle. Depends on ents_pkg.
module ents_dist #(
    parameter int NUM_STOPS   = 6,
    parameter int COLUMN_BITS = 12
) (
    input  logic                                       clk,
    input  logic                                       rst_n,
    input  logic                                       start,
    input  logic [COLUMN_BITS-1:0]                     col,
    input  logic [ents_pkg::COUNT_BITS-1:0]            stop_count,
    input  logic [NUM_STOPS-1:0][ents_pkg::STOP_BITS-1:0] stops,
    input  logic [ents_pkg::IV_BITS-1:0]               interval,
    output logic                                       done,
    output logic [((COLUMN_BITS > ents_pkg::STOP_BITS) ?
                   COLUMN_BITS : ents_pkg::STOP_BITS)-1:0] stop_dist
);
    import ents_pkg::*;

    localparam int DW = (COLUMN_BITS > STOP_BITS) ? COLUMN_BITS : STOP_BITS;
    localparam int IW = (NUM_STOPS > 1) ? $clog2(NUM_STOPS) : 1;
    localparam int BW = $clog2(DW + 1);

    dist_state_t          state_reg, state_next;
    logic [IW-1:0]        idx_reg, idx_next;
    logic [DW-1:0]        off_reg, off_next;
    logic [IV_BITS-1:0]   rem_reg, rem_next;
    logic [BW-1:0]        bit_reg, bit_next;

    logic [COUNT_BITS-1:0] n_eff;
    logic [IV_BITS-1:0]    iv;
    logic [DW-1:0]         stop_ext;
    logic [DW-1:0]         col_ext;
    logic [DW-1:0]         base;
    logic [IV_BITS:0]      shifted;
    logic [DW:0]           sub_a, sub_b, diff;
    logic                  borrow;
    logic                  hit;
    logic                  at_final_stop;

    // Clamp the stop count and the interval
    assign n_eff = (stop_count > COUNT_BITS'(NUM_STOPS)) ? COUNT_BITS'(NUM_STOPS) : stop_count;
    assign iv    = (interval == '0) ? FALLBACK_INTERVAL : interval;

    // One read of the stop table serves both the scan and the base lookup
    assign stop_ext      = DW'(stops[idx_reg]);
    assign col_ext       = DW'(col);
    assign base          = (n_eff != '0) ? stop_ext : '0;
    assign shifted       = {rem_reg, off_reg[DW-1]};
    assign at_final_stop = (COUNT_BITS'(idx_reg) == n_eff - COUNT_BITS'(1));

    // Operand select for the shared subtractor
    always_comb
    begin
        unique case (state_reg)
            D_SEARCH:
            begin
                sub_a = {1'b0, stop_ext};
                sub_b = {1'b0, col_ext};
            end
            D_BASE:
            begin
                sub_a = {1'b0, col_ext};
                sub_b = {1'b0, base};
            end
            D_MOD:
            begin
                sub_a = (DW+1)'(shifted);
                sub_b = (DW+1)'(iv);
            end
            D_FINAL:
            begin
                sub_a = (DW+1)'(iv);
                sub_b = (DW+1)'(rem_reg);
            end
            default:
            begin
                sub_a = '0;
                sub_b = '0;
            end
        endcase
    end

    assign diff   = sub_a - sub_b;
    assign borrow = diff[DW];
    assign hit    = !borrow && (diff[DW-1:0] != '0);

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            D_IDLE:
            begin
                if (start)
                begin
                    state_next = (n_eff == '0) ? D_BASE : D_SEARCH;
                end
            end
            D_SEARCH:
            begin
                if (hit)
                begin
                    state_next = D_IDLE;
                end
                else if (at_final_stop)
                begin
                    state_next = D_BASE;
                end
            end
            D_BASE:
            begin
                state_next = D_MOD;
            end
            D_MOD:
            begin
                if (bit_reg == BW'(1))
                begin
                    state_next = D_FINAL;
                end
            end
            D_FINAL:
            begin
                state_next = D_IDLE;
            end
            default:
            begin
                state_next = D_IDLE;
            end
        endcase
    end

    // Outputs
    always_comb
    begin
        done      = ((state_reg == D_SEARCH) && hit) || (state_reg == D_FINAL);
        stop_dist = diff[DW-1:0];
    end

    // Datapath next values
    always_comb
    begin
        idx_next = idx_reg;
        off_next = off_reg;
        rem_next = rem_reg;
        bit_next = bit_reg;
        unique case (state_reg)
            D_IDLE:
            begin
                idx_next = '0;
            end
            D_SEARCH:
            begin
                if (!hit && !at_final_stop)
                begin
                    idx_next = idx_reg + IW'(1);
                end
            end
            D_BASE:
            begin
                off_next = diff[DW-1:0];
                rem_next = '0;
                bit_next = BW'(DW);
            end
            D_MOD:
            begin
                // Restoring remainder step: keep the difference when it fits
                off_next = {off_reg[DW-2:0], 1'b0};
                rem_next = borrow ? shifted[IV_BITS-1:0] : diff[IV_BITS-1:0];
                bit_next = bit_reg - BW'(1);
            end
            default:
            begin
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= D_IDLE;
            idx_reg   <= '0;
            bit_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
            bit_reg   <= bit_next;
        end
    end

    // Working values
    always_ff @(posedge clk)
    begin
        off_reg <= off_next;
        rem_reg <= rem_next;
    end

endmodule

/* src/entab_tab_stops.sv */
// Top level of the entab block: turns blank runs that reach a tab stop into tabs.
// Holds the column, the held blank count and the output register; the stop
// distance comes from ents_dist. Depends on ents_pkg and ents_dist.
//
//  channel   | direction | signals                          | contents
//  ----------+-----------+----------------------------------+--------------------------
//  s_axis    | in        | tvalid, tready, tdata[7:0]       | in_byte
//  m_axis    | out       | tvalid, tready, tdata[7:0], tlast| out_byte, last
//  cfg       | in        | cfg_we, cfg_index[2:0], cfg_data | registers 0..7, write only
//
// A blank or tab waits in S_DIST while ents_dist scans the user stops in use; past
// the last user stop it also works out the bit-serial remainder over the DW bits
// of the column offset, DW being the wider of COLUMN_BITS and 12. Any other byte
// goes straight from S_IDLE to S_PLAN. Result beats leave through the output register.
// Reset clears the column and held blanks and restores register defaults.
// A stalled m_axis holds the sequencer; s_axis is taken only when it is idle.
module entab_tab_stops #(
    parameter int NUM_STOPS   = 6,
    parameter int COLUMN_BITS = 12
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    input  logic [ents_pkg::BYTE_BITS-1:0]      s_axis_tdata,   // [7:0] in_byte
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    output logic [ents_pkg::BYTE_BITS-1:0]      m_axis_tdata,   // [7:0] out_byte
    output logic                                m_axis_tlast,
    input  logic                                cfg_we,
    input  logic [ents_pkg::CFG_IDX_BITS-1:0]   cfg_index,
    input  logic [ents_pkg::CFG_DATA_BITS-1:0]  cfg_data
);
    import ents_pkg::*;

    localparam int DW = (COLUMN_BITS > STOP_BITS) ? COLUMN_BITS : STOP_BITS;
    localparam logic [COLUMN_BITS-1:0] COL_MAX = '1;

    // Configuration registers
    logic [COUNT_BITS-1:0]               stop_count_reg;
    logic [NUM_STOPS-1:0][STOP_BITS-1:0] stop_reg;
    logic [IV_BITS-1:0]                  interval_reg;

    // Sequencer and line state
    ents_state_t           state_reg, state_next;
    logic [COLUMN_BITS-1:0] column_reg, column_next;
    logic [RUN_BITS-1:0]   pending_reg, pending_next;
    logic [RUN_BITS-1:0]   cnt_reg, cnt_next;
    logic                  tail_reg, tail_next;
    logic [BYTE_BITS-1:0]  byte_reg, byte_next;
    logic [BYTE_BITS-1:0]  fin_reg, fin_next;
    logic [DW-1:0]         d_reg, d_next;

    // Output register
    logic                  m_valid_reg, m_valid_next;
    logic [BYTE_BITS-1:0]  m_data_reg, m_data_next;
    logic                  m_last_reg, m_last_next;

    logic                  accept;
    logic                  needs_dist;
    logic                  ob_free;
    logic                  emit;
    logic [BYTE_BITS-1:0]  emit_byte;
    logic                  emit_last;
    logic                  dist_start;
    logic                  dist_done;
    logic [DW-1:0]         stop_dist;
    logic [DW:0]           col_plus_d;
    logic [COLUMN_BITS-1:0] col_inc;
    logic [COLUMN_BITS-1:0] col_tab;
    logic                  blank_in;

    assign s_axis_tready = (state_reg == S_IDLE);
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign needs_dist    = (s_axis_tdata == CH_BLANK) || (s_axis_tdata == CH_TAB);
    assign ob_free       = !m_valid_reg || m_axis_tready;
    assign blank_in      = (byte_reg == CH_BLANK);

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;
    assign m_axis_tlast  = m_last_reg;

    // Stop distance for the current column
    ents_dist #(
        .NUM_STOPS   (NUM_STOPS),
        .COLUMN_BITS (COLUMN_BITS)
    ) u_dist (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (dist_start),
        .col        (column_reg),
        .stop_count (stop_count_reg),
        .stops      (stop_reg),
        .interval   (interval_reg),
        .done       (dist_done),
        .stop_dist  (stop_dist)
    );

    // Saturating column advance
    assign col_inc    = (column_reg == COL_MAX) ? COL_MAX : column_reg + COLUMN_BITS'(1);
    assign col_plus_d = {1'b0, DW'(column_reg)} + {1'b0, d_reg};
    assign col_tab    = (col_plus_d > (DW+1)'(COL_MAX)) ? COL_MAX
                                                        : col_plus_d[COLUMN_BITS-1:0];

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = needs_dist ? S_DIST : S_PLAN;
                end
            end
            S_DIST:
            begin
                if (dist_done)
                begin
                    state_next = S_PLAN;
                end
            end
            S_PLAN:
            begin
                if (cnt_next != '0)
                begin
                    state_next = S_SPACE;
                end
                else if (tail_next)
                begin
                    state_next = S_LAST;
                end
                else
                begin
                    state_next = S_IDLE;
                end
            end
            S_SPACE:
            begin
                if (ob_free && (cnt_reg == RUN_BITS'(1)))
                begin
                    state_next = tail_reg ? S_LAST : S_IDLE;
                end
            end
            S_LAST:
            begin
                if (ob_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Sequencer outputs
    always_comb
    begin
        emit       = 1'b0;
        emit_byte  = CH_BLANK;
        emit_last  = 1'b0;
        dist_start = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                dist_start = accept && needs_dist;
            end
            S_SPACE:
            begin
                emit      = ob_free;
                emit_last = (cnt_reg == RUN_BITS'(1)) && !tail_reg;
            end
            S_LAST:
            begin
                emit      = ob_free;
                emit_byte = fin_reg;
                emit_last = 1'b1;
            end
            default:
            begin
            end
        endcase
    end

    // Line state and result plan
    always_comb
    begin
        column_next  = column_reg;
        pending_next = pending_reg;
        cnt_next     = cnt_reg;
        tail_next    = tail_reg;
        fin_next     = fin_reg;
        byte_next    = byte_reg;
        d_next       = d_reg;

        // Capture the byte and the distance
        if (accept)
        begin
            byte_next = s_axis_tdata;
        end
        if ((state_reg == S_DIST) && dist_done)
        begin
            d_next = stop_dist;
        end

        unique case (state_reg)
            S_PLAN:
            begin
                if (blank_in)
                begin
                    column_next = col_inc;
                    if (d_reg == DW'(1))
                    begin
                        // Blank reaches a stop: one tab, or a space with nothing held
                        cnt_next     = '0;
                        tail_next    = 1'b1;
                        fin_next     = (pending_reg != '0) ? CH_TAB : CH_BLANK;
                        pending_next = '0;
                    end
                    else if (pending_reg == RUN_CAP)
                    begin
                        // Run full: flush it and start a new one
                        cnt_next     = RUN_CAP;
                        tail_next    = 1'b0;
                        pending_next = RUN_BITS'(1);
                    end
                    else
                    begin
                        cnt_next     = '0;
                        tail_next    = 1'b0;
                        pending_next = pending_reg + RUN_BITS'(1);
                    end
                end
                else
                begin
                    // Flush held blanks, then pass the byte
                    cnt_next     = pending_reg;
                    tail_next    = 1'b1;
                    fin_next     = byte_reg;
                    pending_next = '0;
                    if (byte_reg == CH_NL)
                    begin
                        column_next = '0;
                    end
                    else if (byte_reg == CH_TAB)
                    begin
                        column_next = col_tab;
                    end
                    else
                    begin
                        column_next = col_inc;
                    end
                end
            end
            S_SPACE:
            begin
                if (ob_free)
                begin
                    cnt_next = cnt_reg - RUN_BITS'(1);
                end
            end
            default:
            begin
            end
        endcase
    end

    // Output register: load on emit, drop when taken
    always_comb
    begin
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        m_last_next  = m_last_reg;
        if (emit)
        begin
            m_valid_next = 1'b1;
            m_data_next  = emit_byte;
            m_last_next  = emit_last;
        end
        else if (m_axis_tready)
        begin
            m_valid_next = 1'b0;
        end
    end

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stop_count_reg <= '0;
            interval_reg   <= INTERVAL_RESET;
            for (int g = 0; g < NUM_STOPS; g++)
            begin
                stop_reg[g] <= STOP_RESET;
            end
        end
        else if (cfg_we)
        begin
            if (cfg_index == REG_STOP_COUNT)
            begin
                stop_count_reg <= cfg_data[COUNT_BITS-1:0];
            end
            if (cfg_index == REG_INTERVAL)
            begin
                interval_reg <= cfg_data[IV_BITS-1:0];
            end
            for (int g = 0; g < NUM_STOPS; g++)
            begin
                if (cfg_index == REG_STOP_A + CFG_IDX_BITS'(g))
                begin
                    stop_reg[g] <= cfg_data[STOP_BITS-1:0];
                end
            end
        end
    end

    // Control and line state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            column_reg  <= '0;
            pending_reg <= '0;
            cnt_reg     <= '0;
            tail_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            column_reg  <= column_next;
            pending_reg <= pending_next;
            cnt_reg     <= cnt_next;
            tail_reg    <= tail_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Payload
    always_ff @(posedge clk)
    begin
        byte_reg   <= byte_next;
        fin_reg    <= fin_next;
        d_reg      <= d_next;
        m_data_reg <= m_data_next;
        m_last_reg <= m_last_next;
    end

`ifndef ASSERT_OFF
    // No second byte is taken right after one
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> !s_axis_tready)
        else $error("input taken while previous byte in flight");

    // Distance is never zero for a blank or tab
    a_dist_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == S_PLAN) && ((byte_reg == CH_BLANK) || (byte_reg == CH_TAB)))
        |-> (d_reg != '0))
        else $error("zero distance to tab stop");

    // Flush loop always has a space left to send
    a_space_count: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SPACE) |-> (cnt_reg != '0))
        else $error("space flush with empty count");

    // Distance unit answers only while waited on
    a_done_in_dist: assert property (@(posedge clk) disable iff (!rst_n)
        dist_done |-> (state_reg == S_DIST))
        else $error("distance result outside wait state");
`endif

endmodule
